@@ rtl/core/frls_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frls_pkg: shared types and constants of the flash record log store
// Request modes, result kinds and the classified command passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package frls_pkg;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned SlotW  = 8;

  localparam logic [KeyW-1:0] EMPTY_KEY = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_SCAN  = 2'd1,
    MODE_GET   = 2'd2,
    MODE_SET   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_READ    = 2'd1,
    KIND_ERASE   = 2'd2,
    KIND_PROGRAM = 2'd3
  } kind_e;

  typedef struct packed {
    mode_e             mode;
    logic              in_range;  // key below the number of cached keys
    logic              empty;     // key is the empty record marker
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/frls_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frls_req_if: request channel of the flash record log store
// Valid/ready handshake carrying mode, key and value.
// ----------------------------------------------------------------------------
interface frls_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  mode;
  logic        [15:0] key;
  logic signed [31:0] value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink   (input valid, input mode, input key, input value, output ready);
endinterface
`default_nettype wire

@@ rtl/core/frls_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frls_rsp_if: result channel of the flash record log store
// Valid/ready handshake carrying one acknowledge, read or flash command.
// ----------------------------------------------------------------------------
interface frls_rsp_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic        [7:0]  record_slot;
  logic        [15:0] record_key;
  logic signed [31:0] data;
  logic               last;

  modport source (output valid, output kind, output record_slot, output record_key,
                  output data, output last, input ready);
  modport sink   (input valid, input kind, input record_slot, input record_key,
                  input data, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/frls_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frls_front: request intake and classification
// Decodes each request (mode, key range, empty marker) and holds it in a
// two-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
module frls_front import frls_pkg::*; #(
  parameter int unsigned NUM_KEYS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  frls_req_if.sink    req_i,
  output cmd_t        cmd_o,
  output logic        cmd_valid_o,
  input  wire logic   cmd_pop_i
);

  localparam int unsigned Depth = 2;

  cmd_t       fifo_q [Depth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.mode     = mode_e'(req_i.mode);
    cmd_in.in_range = (req_i.key < KeyW'(NUM_KEYS));
    cmd_in.empty    = (req_i.key == EMPTY_KEY);
    cmd_in.key      = req_i.key;
    cmd_in.value    = req_i.value;
  end

  assign req_i.ready = (cnt_q != 2'(Depth));
  assign push        = req_i.valid && req_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd_in;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(Depth)) else $error("queue count beyond depth");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("push lost");
  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> cnt_q == $past(cnt_q) - 2'd1) else $error("pop lost");

endmodule
`default_nettype wire

@@ rtl/core/frls_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frls_back: command execution
// Holds the value cache, log pointer and scan flag; runs one command at a
// time and walks the cache for compaction when the log is full.
// ----------------------------------------------------------------------------
module frls_back import frls_pkg::*; #(
  parameter int unsigned NUM_KEYS    = 16,
  parameter int unsigned LOG_RECORDS = 170
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cmd_t   cmd_i,
  input  wire logic   cmd_valid_i,
  output logic        cmd_pop_o,
  frls_rsp_if.source  rsp_o
);

  localparam int unsigned KidxW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CRD,
    ST_CWR
  } state_e;

  state_e              state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [KidxW-1:0]    k_q, k_d;
  logic [SlotW-1:0]    ptr_q, ptr_d;
  logic                ended_q, ended_d;
  logic [NUM_KEYS-1:0] vld_q, vld_d;

  logic                out_valid_q, out_valid_d;
  kind_e               out_kind_q, out_kind_d;
  logic [SlotW-1:0]    out_slot_q, out_slot_d;
  logic [KeyW-1:0]     out_key_q, out_key_d;
  logic [ValueW-1:0]   out_data_q, out_data_d;
  logic                out_last_q, out_last_d;

  logic [ValueW-1:0]   mem_q [NUM_KEYS];
  logic [ValueW-1:0]   rd_data_q;
  logic                mem_re, mem_we;
  logic [KidxW-1:0]    mem_raddr;
  logic [KidxW-1:0]    cmd_idx;
  logic [ValueW-1:0]   cur;
  logic                out_free;
  logic                k_last;

  assign cmd_idx  = cmd_q.key[KidxW-1:0];
  assign out_free = !out_valid_q || rsp_o.ready;
  assign k_last   = (k_q == KidxW'(NUM_KEYS - 1));

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    k_d         = k_q;
    ptr_d       = ptr_q;
    ended_d     = ended_q;
    vld_d       = vld_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_kind_d  = out_kind_q;
    out_slot_d  = out_slot_q;
    out_key_d   = out_key_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    cmd_pop_o   = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_raddr   = cmd_i.key[KidxW-1:0];
    cur         = vld_q[cmd_idx] ? rd_data_q : '0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          mem_re    = 1'b1;
          cmd_d     = cmd_i;
          state_d   = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_ACK;
          out_slot_d  = '0;
          out_key_d   = '0;
          out_data_d  = '0;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
          case (cmd_q.mode)
            MODE_CLEAR: begin
              vld_d   = '0;
              ptr_d   = '0;
              ended_d = 1'b0;
            end
            MODE_SCAN: begin
              if (!ended_q && ptr_q < SlotW'(LOG_RECORDS)) begin
                if (cmd_q.empty) begin
                  ended_d = 1'b1;
                end else begin
                  ptr_d = ptr_q + 1'b1;
                  if (cmd_q.in_range) begin
                    mem_we         = 1'b1;
                    vld_d[cmd_idx] = 1'b1;
                  end
                end
              end
            end
            MODE_GET: begin
              out_kind_d = KIND_READ;
              out_data_d = cmd_q.in_range ? cur : '0;
            end
            MODE_SET: begin
              if (cmd_q.in_range && cur != cmd_q.value) begin
                mem_we         = 1'b1;
                vld_d[cmd_idx] = 1'b1;
                if (ptr_q >= SlotW'(LOG_RECORDS)) begin
                  // log full: erase, then rewrite every key
                  out_kind_d = KIND_ERASE;
                  out_last_d = 1'b0;
                  k_d        = '0;
                  state_d    = ST_CRD;
                end else begin
                  out_kind_d = KIND_PROGRAM;
                  out_slot_d = ptr_q;
                  out_key_d  = cmd_q.key;
                  out_data_d = cmd_q.value;
                  ptr_d      = ptr_q + 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_CRD: begin
        mem_re    = 1'b1;
        mem_raddr = k_q;
        state_d   = ST_CWR;
      end

      ST_CWR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_PROGRAM;
          out_slot_d  = SlotW'(k_q);
          out_key_d   = KeyW'(k_q);
          out_data_d  = vld_q[k_q] ? rd_data_q : '0;
          out_last_d  = k_last;
          if (k_last) begin
            ptr_d   = SlotW'(NUM_KEYS);
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_CRD;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      ptr_q       <= '0;
      ended_q     <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      ptr_q       <= ptr_d;
      ended_q     <= ended_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    out_kind_q <= out_kind_d;
    out_slot_q <= out_slot_d;
    out_key_q  <= out_key_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  // value cache
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[cmd_idx] <= cmd_q.value;
    if (mem_re) rd_data_q <= mem_q[mem_raddr];
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.kind        = out_kind_q;
  assign rsp_o.record_slot = out_slot_q;
  assign rsp_o.record_key  = out_key_q;
  assign rsp_o.data        = out_data_q;
  assign rsp_o.last        = out_last_q;

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= SlotW'(LOG_RECORDS)) else $error("log pointer past end of page");
  a_compact_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CWR && out_free && k_last) |=> ptr_q == SlotW'(NUM_KEYS))
    else $error("pointer not reset after compaction");
  a_erase_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && out_kind_q == KIND_ERASE) |-> !rsp_o.last)
    else $error("erase closed a request");
  a_ended_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ended_q && !(state_q == ST_EXEC && cmd_q.mode == MODE_CLEAR)) |=> ended_q)
    else $error("scan end flag dropped without clear");

endmodule
`default_nettype wire

@@ rtl/core/flash_record_log_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flash_record_log_store: key/value cache over an append-only flash log
// Issues erase and program-record commands for a one-page record log.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and are executed one at a time. Clear,
// scan, get and set each pass a cache read, then update and result; the back
// end takes no new request until the current result is registered, and it
// stalls while the result register is held by the channel. A set that finds
// the log full runs compaction: an erase result, then one program result per
// key, each needing its own cache read. The cache comes out of reset cleared
// by per-key valid bits, so no clearing pass follows reset. Flash unlock,
// programming and busy polling are left to the downstream consumer.
module flash_record_log_store import frls_pkg::*; #(
  parameter int unsigned NUM_KEYS    = 16,
  parameter int unsigned LOG_RECORDS = 170
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  frls_req_if.sink    req_i,
  frls_rsp_if.source  rsp_o
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  frls_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  frls_back #(
    .NUM_KEYS    (NUM_KEYS),
    .LOG_RECORDS (LOG_RECORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .rsp_o       (rsp_o)
  );

endmodule
`default_nettype wire
